@@ design/pal_pkg.sv @@
`timescale 1ns / 1ps

package pal_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;
	localparam int POS_W     = 8;
	localparam int VAL_W     = 32;
	localparam int COUNT_W   = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
		logic [VAL_W-1:0]   read_value;
	} rsp_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} ctl_t;

endpackage

@@ design/pal_cell.sv @@
`timescale 1ns / 1ps

module pal_cell #(
	parameter int IDX   = 0,
	parameter int WIDTH = pal_pkg::WIDTH_DEF
) (
	input  logic                clk,
	input  pal_pkg::ctl_t       ctl,
	input  logic [WIDTH-1:0]    ins_val,
	input  logic [WIDTH-1:0]    left_val,
	input  logic [WIDTH-1:0]    right_val,
	output logic [WIDTH-1:0]    val
);

	localparam logic [pal_pkg::POS_W-1:0] MY_POS = pal_pkg::POS_W'(IDX);

	logic [WIDTH-1:0] val_q;

	// insert: load at pos, take from the left above it; delete: take from the right from pos on
	always_ff @(posedge clk) begin
		priority if (ctl.ins && ctl.pos == MY_POS) begin
			val_q <= ins_val;
		end else if (ctl.ins && ctl.pos < MY_POS) begin
			val_q <= left_val;
		end else if (ctl.del && ctl.pos <= MY_POS) begin
			val_q <= right_val;
		end else begin
			val_q <= val_q;
		end
	end

	assign val = val_q;

endmodule

@@ design/positional_array_list.sv @@
`timescale 1ns / 1ps

// Ordered list of up to DEPTH entries of WIDTH bits, held in a row of cells, one entry per
// cell. Insert and delete shift the cells from the position up, all together, in the cycle
// the transaction is taken; clear and read move no cell. The block takes one request per
// cycle unless the request side stalls, and its result appears in the output register on
// the next cycle. The request side stalls only while a result sits in that register and the
// response side stalls. Each result carries a status (ok, full, empty, illegal position),
// the length after the operation and, for a good read, the entry at the position.
module positional_array_list #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	parameter int WIDTH = pal_pkg::WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pal_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = CNT_W + pal_pkg::POS_W;

	logic [WIDTH-1:0]     cell_val [DEPTH];
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     used_nxt;
	logic                 rsp_valid_q;
	pal_pkg::rsp_t        rsp_q;
	logic                 accept;
	logic [1:0]           status;
	logic                 ins_ok;
	logic                 del_ok;
	logic                 rd_ok;
	logic [pal_pkg::VAL_W-1:0] rd_val;
	logic [CMP_W-1:0]     pos_w;
	logic [CMP_W-1:0]     used_w;
	logic                 is_full;
	logic                 is_empty;
	logic [WIDTH-1:0]     ins_val;
	pal_pkg::ctl_t        ctl;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	assign pos_w    = CMP_W'(req.pos);
	assign used_w   = CMP_W'(used_q);
	assign is_full  = (used_q == CNT_W'(DEPTH));
	assign is_empty = (used_q == '0);

	always_comb begin
		status   = pal_pkg::ST_OK;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok    = 1'b0;
		used_nxt = used_q;
		unique case (req.opcode)
			pal_pkg::OP_INSERT: begin
				priority if (is_full) begin
					status = pal_pkg::ST_FULL;
				end else if (pos_w > used_w) begin
					status = pal_pkg::ST_BADPOS;
				end else begin
					ins_ok   = 1'b1;
					used_nxt = used_q + CNT_W'(1);
				end
			end
			pal_pkg::OP_DELETE: begin
				priority if (is_empty) begin
					status = pal_pkg::ST_EMPTY;
				end else if (pos_w >= used_w) begin
					status = pal_pkg::ST_BADPOS;
				end else begin
					del_ok   = 1'b1;
					used_nxt = used_q - CNT_W'(1);
				end
			end
			pal_pkg::OP_CLEAR: begin
				used_nxt = '0;
			end
			pal_pkg::OP_READ: begin
				priority if (is_empty) begin
					status = pal_pkg::ST_EMPTY;
				end else if (pos_w >= used_w) begin
					status = pal_pkg::ST_BADPOS;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				status = pal_pkg::ST_OK;
			end
		endcase
	end

	// a good read has pos below the length, so the low bits index a real cell
	assign rd_val = rd_ok ? pal_pkg::VAL_W'(cell_val[req.pos[IDX_W-1:0]]) : '0;

	assign ins_val = WIDTH'(req.item_value);
	assign ctl.ins = accept & ins_ok;
	assign ctl.del = accept & del_ok;
	assign ctl.pos = req.pos;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] left_val;
		logic [WIDTH-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_left
			assign left_val = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_right
			assign right_val = cell_val[i+1];
		end
		pal_cell #(
			.IDX   (i),
			.WIDTH (WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.ins_val   (ins_val),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q <= used_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= status;
			rsp_q.count      <= pal_pkg::COUNT_W'(used_nxt);
			rsp_q.read_value <= rd_val;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/pal_chk.sv @@
`timescale 1ns / 1ps

module pal_chk #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pal_pkg::rsp_t rsp
);

	// a taken transaction always shows up as a result on the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request produced no result");

	// the request side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a blocked result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == pal_pkg::ST_FULL
		|-> rsp.count == pal_pkg::COUNT_W'(DEPTH))
		else $error("full status with short list");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == pal_pkg::ST_EMPTY |-> rsp.count == '0)
		else $error("empty status with nonzero length");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pal_pkg::ST_OK |-> rsp.read_value == '0)
		else $error("failed request returned data");

endmodule

bind positional_array_list pal_chk #(
	.DEPTH (DEPTH)
) u_pal_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
